FILE: hw/rtl/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// Used by the multiplier, the divider and the top level; no dependencies.
`default_nettype none
package cau_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_EXPONENT = 64;
    localparam int PART_W       = 32;
    localparam int PROD_W       = 2 * PART_W;
    localparam int ACC_W        = PROD_W + 1;
    localparam int DVD_W        = PROD_W + FRAC_BITS;
    localparam int DCNT_W       = $clog2(DVD_W + 1);
    localparam int ECNT_W       = $clog2(MAX_EXPONENT + 1);
    localparam int QUO_W        = PART_W + 1;

    // Actions
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_SUB   = 3'd1;
    localparam logic [2:0] ACT_MUL   = 3'd2;
    localparam logic [2:0] ACT_DIV   = 3'd3;
    localparam logic [2:0] ACT_CONJ  = 3'd4;
    localparam logic [2:0] ACT_EQ    = 3'd5;
    localparam logic [2:0] ACT_NEAR  = 3'd6;
    localparam logic [2:0] ACT_POW   = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic [PART_W-1:0] SAT_MAX = {1'b0, {(PART_W-1){1'b1}}};
    localparam logic [PART_W-1:0] SAT_MIN = {1'b1, {(PART_W-1){1'b0}}};
    localparam logic [PART_W-1:0] FX_ONE  = PART_W'(1) << FRAC_BITS;

    // Register map
    localparam logic REG_TOL = 1'b0;

    typedef struct packed {
        logic [PART_W-1:0] val;
        logic              sat;
    } t_sat;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_res;
endpackage
`default_nettype wire

FILE: hw/rtl/cau_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on cau_pkg.
`default_nettype none
module cau_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [cau_pkg::PART_W-1:0]   i_a,
    input  wire logic signed [cau_pkg::PART_W-1:0]   i_b,
    output logic signed [cau_pkg::PROD_W-1:0]        o_p
);
    import cau_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // Register the product; the sequencer reads the registered value
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

FILE: hw/rtl/cau_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// Keeps the low quotient bits and a sticky overflow flag. Depends on cau_pkg.
`default_nettype none
module cau_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [cau_pkg::PROD_W-1:0]   i_num,
    input  wire logic [cau_pkg::PROD_W-1:0]   i_den,
    output cau_pkg::t_div_res                 o_res
);
    import cau_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_den;
    logic [QUO_W-1:0]  r_quo;
    logic              r_ovf;

    logic [PROD_W:0]   rem2;
    logic [PROD_W:0]   diff;
    logic              ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem2 = {r_rem, r_dvd[DVD_W-1]};
        diff = rem2 - {1'b0, r_den};
        ge   = (rem2 >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? diff[PROD_W-1:0] : rem2[PROD_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_ovf <= r_ovf | r_quo[QUO_W-1];
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_quo;
endmodule
`default_nettype wire

FILE: hw/rtl/complex_arith_unit.sv
// Complex arithmetic unit on signed Q16.16 operands. One item is in flight at a
// time, and the input is not ready again until the result beat has been taken.
// Add, subtract, conjugate, equal and near load the result register straight from
// the accepted beat; multiply runs four products through one shared 32x32
// multiplier, then floor and clip; divide runs six products, the zero check,
// then two 80-step restoring divisions, one per result part, or stops at the
// zero check with a saturated result when y is zero; power repeats the multiply
// up to 64 times, after taking the reciprocal of x when the exponent is negative
// (a saturated divide-by-zero result when x is zero).
// The shared multiplier and the bit-serial divider set the pace of these sequences.
// near_tolerance lives at byte address 0 of the configuration port.
`default_nettype none
module complex_arith_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [135:0] i_s_tdata,  // x_re, x_im, y_re, y_im, exponent
    input  wire logic [2:0]   i_s_tuser,  // action
    // Output stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,  // z_re, z_im
    output logic [2:0]        o_m_tuser,  // match, status
    // Configuration
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [2:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);
    import cau_pkg::*;
    `include "complex_arith_unit_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_MFIN, S_DCHK, S_DIV_RE, S_DIV_IM
    } t_state;

    t_state                   r_state;
    logic [2:0]               r_step;
    logic [2:0]               r_act;
    logic                     r_is_div;
    logic [ECNT_W-1:0]        r_cnt;
    logic signed [PART_W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic [PROD_W-1:0]        r_den;
    logic                     r_sat, r_dz;
    logic [15:0]              r_tol;
    logic                     r_out_valid;
    logic [PART_W-1:0]        r_z_re, r_z_im;
    logic                     r_match;
    logic [1:0]               r_status;

    logic signed [PART_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  p_ext;
    logic                     div_start;
    logic [PROD_W-1:0]        div_num;
    t_div_res                 div_res;

    logic                     accept;
    logic signed [PART_W-1:0] in_xr, in_xi, in_yr, in_yi;
    logic signed [7:0]        in_exp;
    logic [7:0]               exp_mag;
    logic [ECNT_W-1:0]        exp_n;
    t_sat                     add_re, add_im, sub_re, sub_im, conj_im;
    t_sat                     fl_re, fl_im, q_sat;
    logic signed [PART_W:0]   d_re, d_im;
    logic signed [PART_W:0]   tol_ext;
    logic                     near_ok;
    logic                     acc_neg;

    // Clip a signed value to the 32-bit range
    function automatic t_sat f_clip(input logic signed [ACC_W-1-FRAC_BITS:0] v);
        t_sat r;
        if (v > $signed({{(ACC_W-FRAC_BITS-PART_W){1'b0}}, SAT_MAX})) begin
            r.val = SAT_MAX;
            r.sat = 1'b1;
        end else if (v < $signed({{(ACC_W-FRAC_BITS-PART_W){1'b1}}, SAT_MIN})) begin
            r.val = SAT_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = v[PART_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clip
    function automatic t_sat f_quo(input logic neg, input logic ovf,
                                   input logic [QUO_W-1:0] mag);
        t_sat r;
        if (!neg) begin
            r.sat = ovf || (mag > {1'b0, SAT_MAX});
            r.val = r.sat ? SAT_MAX : mag[PART_W-1:0];
        end else begin
            r.sat = ovf || (mag > {1'b0, SAT_MIN});
            r.val = r.sat ? SAT_MIN : PART_W'(-mag);
        end
        return r;
    endfunction

    // Unpack the input beat
    assign in_xr  = i_s_tdata[31:0];
    assign in_xi  = i_s_tdata[63:32];
    assign in_yr  = i_s_tdata[95:64];
    assign in_yi  = i_s_tdata[127:96];
    assign in_exp = i_s_tdata[135:128];
    assign accept = i_s_tvalid && o_s_tready;

    // Exponent magnitude, clamped
    always_comb begin
        exp_mag = in_exp[7] ? 8'(-in_exp) : 8'(in_exp);
        exp_n   = (exp_mag > 8'(MAX_EXPONENT)) ? ECNT_W'(MAX_EXPONENT) : exp_mag[ECNT_W-1:0];
    end

    // Actions computed straight from the input beat
    always_comb begin
        add_re  = f_clip(49'(in_xr) + 49'(in_yr));
        add_im  = f_clip(49'(in_xi) + 49'(in_yi));
        sub_re  = f_clip(49'(in_xr) - 49'(in_yr));
        sub_im  = f_clip(49'(in_xi) - 49'(in_yi));
        conj_im = f_clip(-49'(in_xi));
        d_re    = 33'(in_xr) - 33'(in_yr);
        d_im    = 33'(in_xi) - 33'(in_yi);
        tol_ext = $signed({17'd0, r_tol});
        near_ok = (d_re > -tol_ext) && (d_re < tol_ext)
               && (d_im > -tol_ext) && (d_im < tol_ext);
    end

    // Operand select for the shared multiplier
    always_comb begin
        case (r_step)
            3'd1:    begin mul_a = r_ai; mul_b = r_bi; end
            3'd2:    begin mul_a = r_ar; mul_b = r_bi; end
            3'd3:    begin mul_a = r_ai; mul_b = r_br; end
            3'd4:    begin mul_a = r_br; mul_b = r_br; end
            3'd5:    begin mul_a = r_bi; mul_b = r_bi; end
            default: begin mul_a = r_ar; mul_b = r_br; end
        endcase
    end

    cau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign p_ext = ACC_W'(prod);

    // Floor and clip the complex product
    assign fl_re = f_clip(r_acc_re[ACC_W-1:FRAC_BITS]);
    assign fl_im = f_clip(r_acc_im[ACC_W-1:FRAC_BITS]);

    // Divider feed: real part first, then imaginary
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        if (r_state == S_DCHK && r_den != '0) begin
            div_start = 1'b1;
            div_num   = r_acc_re[ACC_W-1] ? PROD_W'(-r_acc_re) : PROD_W'(r_acc_re);
        end else if (r_state == S_DIV_RE && div_res.done) begin
            div_start = 1'b1;
            div_num   = r_acc_im[ACC_W-1] ? PROD_W'(-r_acc_im) : PROD_W'(r_acc_im);
        end
    end

    cau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_res   (div_res)
    );

    assign acc_neg = (r_state == S_DIV_RE) ? r_acc_re[ACC_W-1] : r_acc_im[ACC_W-1];
    assign q_sat   = f_quo(acc_neg, div_res.ovf, div_res.quo);

    // Sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act    <= i_s_tuser;
                        r_sat    <= 1'b0;
                        r_dz     <= 1'b0;
                        r_step   <= '0;
                        r_cnt    <= exp_n;
                        r_match  <= 1'b0;
                        r_status <= ST_OK;
                        r_z_re   <= '0;
                        r_z_im   <= '0;
                        case (i_s_tuser)
                            ACT_ADD: begin
                                r_z_re      <= add_re.val;
                                r_z_im      <= add_im.val;
                                r_status    <= (add_re.sat || add_im.sat) ? ST_SAT : ST_OK;
                                r_out_valid <= 1'b1;
                            end
                            ACT_SUB: begin
                                r_z_re      <= sub_re.val;
                                r_z_im      <= sub_im.val;
                                r_status    <= (sub_re.sat || sub_im.sat) ? ST_SAT : ST_OK;
                                r_out_valid <= 1'b1;
                            end
                            ACT_CONJ: begin
                                r_z_re      <= in_xr;
                                r_z_im      <= conj_im.val;
                                r_status    <= conj_im.sat ? ST_SAT : ST_OK;
                                r_out_valid <= 1'b1;
                            end
                            ACT_EQ: begin
                                r_match     <= (in_xr == in_yr) && (in_xi == in_yi);
                                r_out_valid <= 1'b1;
                            end
                            ACT_NEAR: begin
                                r_match     <= near_ok;
                                r_out_valid <= 1'b1;
                            end
                            ACT_MUL, ACT_DIV: begin
                                r_ar     <= in_xr;
                                r_ai     <= in_xi;
                                r_br     <= in_yr;
                                r_bi     <= in_yi;
                                r_is_div <= (i_s_tuser == ACT_DIV);
                                r_state  <= S_MUL;
                            end
                            default: begin
                                // Power: z starts at one, base is x or 1/x
                                r_ar     <= FX_ONE;
                                r_ai     <= '0;
                                r_br     <= in_xr;
                                r_bi     <= in_xi;
                                r_is_div <= in_exp[7];
                                if (exp_n == '0) begin
                                    r_z_re      <= FX_ONE;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1: r_acc_re <= p_ext;
                        3'd2: r_acc_re <= r_is_div ? r_acc_re + p_ext : r_acc_re - p_ext;
                        3'd3: r_acc_im <= r_is_div ? -p_ext : p_ext;
                        3'd4: begin
                            r_acc_im <= r_acc_im + p_ext;
                            if (!r_is_div) begin
                                r_state <= S_MFIN;
                            end
                        end
                        3'd5: r_den <= prod;
                        3'd6: begin
                            r_den   <= r_den + prod;
                            r_state <= S_DCHK;
                        end
                        default: ;
                    endcase
                end
                S_MFIN: begin
                    r_sat  <= r_sat | fl_re.sat | fl_im.sat;
                    r_ar   <= fl_re.val;
                    r_ai   <= fl_im.val;
                    r_step <= '0;
                    if (r_act == ACT_POW && r_cnt != ECNT_W'(1)) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_z_re      <= fl_re.val;
                        r_z_im      <= fl_im.val;
                        r_status    <= (r_sat || fl_re.sat || fl_im.sat) ? ST_SAT : ST_OK;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DCHK: begin
                    if (r_den == '0) begin
                        // Divide by zero: saturate by the dividend signs
                        r_z_re      <= r_ar[PART_W-1] ? SAT_MIN : SAT_MAX;
                        r_z_im      <= r_ai[PART_W-1] ? SAT_MIN : SAT_MAX;
                        r_status    <= ST_DZ;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_DIV_RE;
                    end
                end
                S_DIV_RE: begin
                    if (div_res.done) begin
                        r_br    <= q_sat.val;
                        r_sat   <= r_sat | q_sat.sat;
                        r_state <= S_DIV_IM;
                    end
                end
                S_DIV_IM: begin
                    if (div_res.done) begin
                        if (r_act == ACT_POW) begin
                            r_bi     <= q_sat.val;
                            r_sat    <= r_sat | q_sat.sat;
                            r_ar     <= FX_ONE;
                            r_ai     <= '0;
                            r_is_div <= 1'b0;
                            r_step   <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            r_z_re      <= r_br;
                            r_z_im      <= q_sat.val;
                            r_status    <= (r_sat || q_sat.sat) ? ST_SAT : ST_OK;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2] == REG_TOL) begin
            r_tol <= i_pwdata[15:0];
        end
    end

    assign o_prdata   = (i_paddr[2] == REG_TOL) ? {16'd0, r_tol} : 32'd0;
    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == S_IDLE) && !r_out_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_z_im, r_z_re};
    assign o_m_tuser  = {r_status, r_match};

    `CAU_ASSERT_IMP(a_ready_no_pending, i_clk, i_rst_n, o_s_tready, !o_m_tvalid, "ready with pending result")
    `CAU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_s_tready, "ready right after accept")
    `CAU_ASSERT_IMP(a_match_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == 64'd0 && o_m_tuser[2:1] == ST_OK, "match with nonzero result")
    `CAU_ASSERT_IMP(a_dz_saturated, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[2:1] == ST_DZ, (o_m_tdata[31:0] == SAT_MAX || o_m_tdata[31:0] == SAT_MIN), "divide by zero not saturated")
endmodule
`default_nettype wire
